// ----- sv/rrrs_pkg.sv -----
`timescale 1ns / 1ps

package rrrs_pkg;

    // Fixed field widths
    localparam int SLOT_W            = 4;
    localparam int MASK_W            = 16;
    localparam int COUNT_W           = 5;
    localparam int DEFAULT_JOB_SLOTS = 16;

    // Command broadcast to every cell of the rotation chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_FILTER,
        CELL_COMPACT,
        CELL_APPEND,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [MASK_W-1:0]   keep;
        logic [SLOT_W-1:0]   new_slot;
    } cell_cmd_t;

    // Mask of the slot numbers that exist for a given slot count
    function automatic logic [MASK_W-1:0] slot_enable(input int n);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < n) begin
                m[k] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ----- sv/rrrs_cell.sv -----
`timescale 1ns / 1ps

module rrrs_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rrrs_pkg::cell_cmd_t           cmd,
    input  logic                          left_valid,
    input  logic                          right_valid,
    input  logic [rrrs_pkg::SLOT_W-1:0]   right_slot,
    output logic                          valid,
    output logic [rrrs_pkg::SLOT_W-1:0]   slot
);
    import rrrs_pkg::*;

    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Gap handling: an empty cell pulls its right neighbor forward,
    // a full cell behind an empty one hands its entry over.
    logic pull;
    logic pulled;

    assign pull   = !valid_reg && right_valid;
    assign pulled = valid_reg && !left_valid;

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                CELL_CLEAR:   valid_reg <= 1'b0;
                CELL_FILTER:  valid_reg <= valid_reg && cmd.keep[slot_reg];
                CELL_COMPACT: begin
                    if (pull) begin
                        valid_reg <= 1'b1;
                    end else if (pulled) begin
                        valid_reg <= 1'b0;
                    end
                end
                CELL_APPEND: begin
                    if (!valid_reg && left_valid) begin
                        valid_reg <= 1'b1;
                    end
                end
                CELL_SHIFT:   valid_reg <= right_valid;
                default:      valid_reg <= valid_reg;
            endcase
        end
    end

    // Slot payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            CELL_COMPACT: begin
                if (pull) begin
                    slot_reg <= right_slot;
                end
            end
            CELL_APPEND: begin
                if (!valid_reg && left_valid) begin
                    slot_reg <= cmd.new_slot;
                end
            end
            CELL_SHIFT:   slot_reg <= right_slot;
            default:      slot_reg <= slot_reg;
        endcase
    end

    assign valid = valid_reg;
    assign slot  = slot_reg;

endmodule

// ----- sv/round_robin_rotation_scheduler.sv -----
`timescale 1ns / 1ps

// Round-robin rotation scheduler. The rotation lives in a chain of JOB_SLOTS
// cells, front at cell 0. A pick drops slots missing from the ready mask,
// appends newly ready slots in ascending order and grants the front slot; an
// empty mask clears the rotation. A completion removes its slot and re-appends
// it at the tail when work is left. One item at a time: an item is taken in
// the idle state. A pick with an empty mask then passes through a clear
// state and a result state. Any other item passes through a filter state, a
// compaction state that stays until no gap is left (gaps move one cell per
// step), an append state that appends one newly ready slot per step, a pop
// state on a pick, and a result state. The result state waits while the
// previous result has not been taken. A finished result sits in the output
// register and the next item is taken while it waits. ready_mask bits at or
// above JOB_SLOTS are ignored.
module round_robin_rotation_scheduler #(
    parameter int JOB_SLOTS = rrrs_pkg::DEFAULT_JOB_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [rrrs_pkg::MASK_W-1:0]    s_ready_mask,
    input  logic [rrrs_pkg::SLOT_W-1:0]    s_done_slot,
    input  logic                           s_work_left,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_grant_valid,
    output logic [rrrs_pkg::SLOT_W-1:0]    m_grant_slot,
    output logic [rrrs_pkg::COUNT_W-1:0]   m_queue_count
);
    import rrrs_pkg::*;

    localparam logic [MASK_W-1:0] SLOT_EN = slot_enable(JOB_SLOTS);
    localparam int                CNT_W   = $clog2(JOB_SLOTS + 1);
    localparam logic              REQ_PICK = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILTER,
        ST_COMPACT,
        ST_APPEND,
        ST_POP,
        ST_RESP
    } state_t;

    state_t             state_reg;
    logic               req_type_reg;
    logic [MASK_W-1:0]  keep_reg;
    logic [MASK_W-1:0]  pend_reg;
    logic [MASK_W-1:0]  member_reg;
    logic               grant_valid_reg;
    logic [SLOT_W-1:0]  grant_slot_reg;
    logic               m_valid_reg;
    logic               m_grant_valid_reg;
    logic [SLOT_W-1:0]  m_grant_slot_reg;
    logic [COUNT_W-1:0] m_queue_count_reg;

    cell_cmd_t          cmd;
    logic               cell_valid [JOB_SLOTS];
    logic [SLOT_W-1:0]  cell_slot  [JOB_SLOTS];

    // Cell chain
    for (genvar i = 0; i < JOB_SLOTS; i++) begin : g_cell
        logic              lv;
        logic              rv;
        logic [SLOT_W-1:0] rs;
        if (i == 0) begin : g_first
            assign lv = 1'b1;
        end else begin : g_mid
            assign lv = cell_valid[i-1];
        end
        if (i == JOB_SLOTS - 1) begin : g_last
            assign rv = 1'b0;
            assign rs = '0;
        end else begin : g_inner
            assign rv = cell_valid[i+1];
            assign rs = cell_slot[i+1];
        end
        rrrs_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_valid  (lv),
            .right_valid (rv),
            .right_slot  (rs),
            .valid       (cell_valid[i]),
            .slot        (cell_slot[i])
        );
    end

    // Chain status: gaps, fill level and length
    logic             has_gap;
    logic             chain_full;
    logic [CNT_W-1:0] chain_len;

    always_comb begin
        has_gap   = 1'b0;
        chain_len = '0;
        for (int i = 0; i < JOB_SLOTS - 1; i++) begin
            has_gap = has_gap | (!cell_valid[i] && cell_valid[i+1]);
        end
        for (int i = 0; i < JOB_SLOTS; i++) begin
            if (!cell_valid[i] && (i == 0 || cell_valid[(i == 0) ? 0 : i-1])) begin
                chain_len = chain_len | CNT_W'(i);
            end
        end
        if (cell_valid[JOB_SLOTS-1]) begin
            chain_len = CNT_W'(JOB_SLOTS);
        end
    end

    assign chain_full = cell_valid[JOB_SLOTS-1];

    // Lowest pending slot to append
    logic [MASK_W-1:0] low_bit;
    logic [SLOT_W-1:0] low_idx;

    always_comb begin
        low_bit = pend_reg & (~pend_reg + MASK_W'(1));
        low_idx = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (low_bit[k]) begin
                low_idx = low_idx | SLOT_W'(k);
            end
        end
    end

    // Input decode
    logic [MASK_W-1:0] mask_in;
    logic [MASK_W-1:0] done_bit;
    logic              done_ok;

    assign mask_in  = s_ready_mask & SLOT_EN;
    assign done_bit = MASK_W'(1) << s_done_slot;
    assign done_ok  = (32'(s_done_slot) < JOB_SLOTS);

    // Command to the chain
    always_comb begin
        cmd.op       = CELL_HOLD;
        cmd.keep     = keep_reg;
        cmd.new_slot = low_idx;
        case (state_reg)
            ST_CLEAR:   cmd.op = CELL_CLEAR;
            ST_FILTER:  cmd.op = CELL_FILTER;
            ST_COMPACT: cmd.op = CELL_COMPACT;
            ST_APPEND: begin
                if (pend_reg != '0) begin
                    cmd.op = CELL_APPEND;
                end
            end
            ST_POP:     cmd.op = CELL_SHIFT;
            default:    cmd.op = CELL_HOLD;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Output register loads when the result is ready and the slot is free
    logic out_load;

    assign out_load = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            member_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_type_reg    <= s_req_type;
                        grant_valid_reg <= 1'b0;
                        grant_slot_reg  <= '0;
                        if (s_req_type == REQ_PICK) begin
                            keep_reg   <= mask_in;
                            pend_reg   <= mask_in & ~member_reg;
                            member_reg <= member_reg & mask_in;
                            state_reg  <= (mask_in == '0) ? ST_CLEAR : ST_FILTER;
                        end else if (done_ok) begin
                            keep_reg   <= ~done_bit;
                            pend_reg   <= s_work_left ? done_bit : '0;
                            member_reg <= member_reg & ~done_bit;
                            state_reg  <= ST_FILTER;
                        end else begin
                            keep_reg  <= '1;
                            pend_reg  <= '0;
                            state_reg <= ST_FILTER;
                        end
                    end
                end
                ST_CLEAR: begin
                    member_reg <= '0;
                    state_reg  <= ST_RESP;
                end
                ST_FILTER: begin
                    state_reg <= ST_COMPACT;
                end
                ST_COMPACT: begin
                    if (!has_gap) begin
                        state_reg <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    if (pend_reg != '0) begin
                        pend_reg <= pend_reg & ~low_bit;
                        if (!chain_full) begin
                            member_reg <= member_reg | low_bit;
                        end
                    end else begin
                        state_reg <= (req_type_reg == REQ_PICK) ? ST_POP : ST_RESP;
                    end
                end
                ST_POP: begin
                    if (cell_valid[0]) begin
                        grant_valid_reg <= 1'b1;
                        grant_slot_reg  <= cell_slot[0];
                        member_reg      <= member_reg & ~(MASK_W'(1) << cell_slot[0]);
                    end
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_load) begin
                        m_grant_valid_reg <= grant_valid_reg;
                        m_grant_slot_reg  <= grant_slot_reg;
                        m_queue_count_reg <= COUNT_W'(chain_len);
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_grant_valid = m_grant_valid_reg;
    assign m_grant_slot  = m_grant_slot_reg;
    assign m_queue_count = m_queue_count_reg;

    // Membership rebuilt from the chain, for checking
    logic [MASK_W-1:0] member_chk;

    always_comb begin
        member_chk = '0;
        for (int i = 0; i < JOB_SLOTS; i++) begin
            if (cell_valid[i]) begin
                member_chk = member_chk | (MASK_W'(1) << cell_slot[i]);
            end
        end
    end

    // Appends only ever see a gap-free chain
    a_compact_before_append: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_APPEND |-> !has_gap)
        else $error("rotation chain has a gap during append");

    // Member flags agree with the chain between items
    a_member_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> member_reg == member_chk)
        else $error("member flags disagree with rotation chain");

    // A result without a grant carries slot zero
    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_grant_valid |-> m_grant_slot == '0)
        else $error("grant slot nonzero without grant");

    // A pick that finds work always grants
    a_pick_grants: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_POP |-> cell_valid[0])
        else $error("pick reached pop with empty rotation");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import rrrs_pkg::*;

    localparam int JOB_SLOTS  = DEFAULT_JOB_SLOTS;
    localparam int QUIET_MAX  = 2000;
    localparam int SETTLE_CYC = 2 * JOB_SLOTS + 8;
    localparam logic [MASK_W-1:0] SLOT_RANGE = MASK_W'((64'd1 << JOB_SLOTS) - 64'd1);

    // Request kinds
    localparam logic REQ_PICK = 1'b0;
    localparam logic REQ_DONE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [MASK_W-1:0]   ready_mask;
        logic [SLOT_W-1:0]   done_slot;
        logic                work_left;
    } sched_req_t;

    typedef struct packed {
        logic                grant_valid;
        logic [SLOT_W-1:0]   grant_slot;
        logic [COUNT_W-1:0]  queue_count;
    } sched_out_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_req_type    = 1'b0;
    logic [MASK_W-1:0]   s_ready_mask  = '0;
    logic [SLOT_W-1:0]   s_done_slot   = '0;
    logic                s_work_left   = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_grant_valid;
    logic [SLOT_W-1:0]   m_grant_slot;
    logic [COUNT_W-1:0]  m_queue_count;

    // Predicted rotation
    logic [SLOT_W-1:0]   rot_slots [JOB_SLOTS];
    int                  rot_len;
    logic [MASK_W-1:0]   members;
    logic [SLOT_W-1:0]   last_grant;

    sched_out_t          pending_grants[$];

    // Stimulus bookkeeping
    bit                  sender_on;
    int                  burst_left;
    logic [MASK_W-1:0]   work_mask;
    int                  fail_count;
    int                  quiet_cycles;
    int                  n_pick, n_grant, n_empty, n_done, n_full;

    round_robin_rotation_scheduler #(
        .JOB_SLOTS(JOB_SLOTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_ready_mask  (s_ready_mask),
        .s_done_slot   (s_done_slot),
        .s_work_left   (s_work_left),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_grant_valid (m_grant_valid),
        .m_grant_slot  (m_grant_slot),
        .m_queue_count (m_queue_count)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Keep only rotation entries whose bit is set in keep, order preserved
    function automatic void drop_missing(input logic [MASK_W-1:0] keep);
        int w;
        w = 0;
        for (int r = 0; r < rot_len; r++) begin
            if (keep[rot_slots[r]]) begin
                rot_slots[w] = rot_slots[r];
                w++;
            end else begin
                members[rot_slots[r]] = 1'b0;
            end
        end
        rot_len = w;
    endfunction

    function automatic void append_slot(input logic [SLOT_W-1:0] s);
        if (rot_len < JOB_SLOTS) begin
            rot_slots[rot_len] = s;
            rot_len++;
            members[s] = 1'b1;
        end
    endfunction

    // Advance the predicted rotation by one request and return its result
    function automatic sched_out_t predict_schedule(input sched_req_t req);
        sched_out_t        res;
        logic [MASK_W-1:0] live;
        res = '0;
        if (req.req_type == REQ_PICK) begin
            live = req.ready_mask & SLOT_RANGE;
            if (live == '0) begin
                rot_len = 0;
                members = '0;
            end else begin
                drop_missing(live);
                for (int i = 0; i < JOB_SLOTS; i++) begin
                    if (live[i] && !members[i]) begin
                        append_slot(SLOT_W'(i));
                    end
                end
                if (rot_len > 0) begin
                    res.grant_valid = 1'b1;
                    res.grant_slot  = rot_slots[0];
                    for (int k = 0; k < rot_len - 1; k++) begin
                        rot_slots[k] = rot_slots[k + 1];
                    end
                    rot_len--;
                    members[res.grant_slot] = 1'b0;
                end
            end
        end else begin
            if (int'(req.done_slot) < JOB_SLOTS) begin
                if (members[req.done_slot]) begin
                    drop_missing(~(MASK_W'(1) << req.done_slot));
                end
                if (req.work_left) begin
                    append_slot(req.done_slot);
                end
            end
        end
        res.queue_count = COUNT_W'(rot_len);
        return res;
    endfunction

    // One input transfer; called and returns at a falling edge
    task automatic send_item(input sched_req_t req);
        sched_out_t res;
        s_req_type   <= req.req_type;
        s_ready_mask <= req.ready_mask;
        s_done_slot  <= req.done_slot;
        s_work_left  <= req.work_left;
        if (!sender_on) begin
            s_valid   <= 1'b1;
            sender_on = 1'b1;
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = predict_schedule(req);
        pending_grants.insert(pending_grants.size(), res);
        if (req.req_type == REQ_PICK) begin
            n_pick++;
            if (res.grant_valid) begin
                n_grant++;
                last_grant = res.grant_slot;
            end else begin
                n_empty++;
            end
        end else begin
            n_done++;
        end
        if (res.queue_count == COUNT_W'(JOB_SLOTS)) n_full++;
        @(negedge aclk);
        // Bursts of random length, then a gap (sometimes none)
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_valid   <= 1'b0;
                sender_on = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
    endtask

    task automatic send_fields(input logic rt, input logic [MASK_W-1:0] mask,
                               input logic [SLOT_W-1:0] ds, input logic wl);
        sched_req_t req;
        req.req_type   = rt;
        req.ready_mask = mask;
        req.done_slot  = ds;
        req.work_left  = wl;
        send_item(req);
    endtask

    // Hold the sender off until every predicted result has arrived
    task automatic drain_results();
        if (sender_on) begin
            s_valid   <= 1'b0;
            sender_on = 1'b0;
        end
        @(posedge aclk);
        while (pending_grants.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Empty rotation: an empty pick and a completion of an absent slot
    task automatic test_empty_rotation();
        send_fields(REQ_PICK, '0, '0, 1'b0);
        send_fields(REQ_DONE, '0, 4'd3, 1'b0);
    endtask

    // Fill the rotation to all slots and exercise completion rules
    task automatic test_full_rotation();
        send_fields(REQ_PICK, '1, '0, 1'b0);
        send_fields(REQ_DONE, '0, 4'd0, 1'b1);
        send_fields(REQ_DONE, '0, 4'd5, 1'b1);
        send_fields(REQ_PICK, '1, '1, 1'b1);
        send_fields(REQ_DONE, '0, 4'd15, 1'b0);
        send_fields(REQ_DONE, '0, 4'd1, 1'b0);
        // completion ignores the ready mask
        send_fields(REQ_DONE, '1, 4'd7, 1'b1);
    endtask

    // Single-bit and alternating masks, clearing a non-empty rotation
    task automatic test_mask_edges();
        send_fields(REQ_PICK, 16'h0001, '0, 1'b0);
        send_fields(REQ_PICK, 16'h8000, '0, 1'b0);
        send_fields(REQ_PICK, 16'hAAAA, '0, 1'b0);
        send_fields(REQ_PICK, 16'h5555, '0, 1'b0);
        send_fields(REQ_PICK, 16'h8001, '0, 1'b0);
        send_fields(REQ_PICK, '0, '1, 1'b1);
        send_fields(REQ_DONE, '0, 4'd0, 1'b1);
        send_fields(REQ_DONE, '0, 4'd15, 1'b1);
    endtask

    // Realistic traffic: slowly drifting ready set, completions of granted jobs
    task automatic test_rotation_traffic(input int n_items);
        sched_req_t req;
        for (int k = 0; k < n_items; k++) begin
            req.done_slot = SLOT_W'($urandom);
            req.work_left = 1'($urandom);
            if ($urandom_range(0, 99) < 60) begin
                req.req_type = REQ_PICK;
                case ($urandom_range(0, 19))
                    0:       work_mask = '1;
                    1, 2:    work_mask = MASK_W'($urandom);
                    3:       work_mask = '0;
                    default: work_mask ^= MASK_W'(1) << $urandom_range(0, MASK_W - 1);
                endcase
                if (work_mask == '0 && $urandom_range(0, 3) != 0) begin
                    work_mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
                end
                req.ready_mask = work_mask;
            end else begin
                req.req_type   = REQ_DONE;
                req.ready_mask = MASK_W'($urandom);
                if ($urandom_range(0, 3) != 0) req.done_slot = last_grant;
                // a job that finished leaves the ready set
                if (!req.work_left) work_mask[req.done_slot] = 1'b0;
            end
            send_item(req);
        end
    endtask

    // Unstructured requests
    task automatic test_random_noise(input int n_items);
        sched_req_t req;
        for (int k = 0; k < n_items; k++) begin
            req.req_type   = 1'($urandom);
            req.ready_mask = ($urandom_range(0, 9) == 0) ? '0 : MASK_W'($urandom);
            req.done_slot  = SLOT_W'($urandom);
            req.work_left  = 1'($urandom);
            send_item(req);
        end
    endtask

    // Receiver back-pressure on a pattern that switches between random modes
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_tick = 0;
    int       rx_hold = 0;
    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 96 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom);
            RX_SPARSE: m_ready <= (rx_tick % 4 == 0);
            default: begin
                if (rx_hold > 0) begin
                    m_ready <= 1'b0;
                    rx_hold--;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 30);
                end
            end
        endcase
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        sched_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result: grant_valid=%0d grant_slot=%0d queue_count=%0d",
                       m_grant_valid, m_grant_slot, m_queue_count);
                fail_count++;
            end else begin
                exp_res = pending_grants[0];
                pending_grants.delete(0);
                if (m_grant_valid !== exp_res.grant_valid) begin
                    $error("grant_valid: expected %0d, got %0d",
                           exp_res.grant_valid, m_grant_valid);
                    fail_count++;
                end
                if (m_grant_slot !== exp_res.grant_slot) begin
                    $error("grant_slot: expected %0d, got %0d",
                           exp_res.grant_slot, m_grant_slot);
                    fail_count++;
                end
                if (m_queue_count !== exp_res.queue_count) begin
                    $error("queue_count: expected %0d, got %0d",
                           exp_res.queue_count, m_queue_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout: no transfer for %0d cycles", QUIET_MAX);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        rot_len    = 0;
        members    = '0;
        last_grant = '0;
        work_mask  = '0;
        sender_on  = 1'b0;
        burst_left = 4;
        fail_count = 0;
        n_pick = 0; n_grant = 0; n_empty = 0; n_done = 0; n_full = 0;
        for (int i = 0; i < JOB_SLOTS; i++) rot_slots[i] = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_rotation();
        test_full_rotation();
        test_mask_edges();
        drain_results();
        test_rotation_traffic(300);
        drain_results();
        test_random_noise(100);

        // Wait for the last results, then let the block settle
        drain_results();
        repeat (SETTLE_CYC) @(posedge aclk);

        $display("run: %0d picks (%0d granted, %0d empty), %0d completions",
                 n_pick, n_grant, n_empty, n_done);
        $display("run: full rotation reached %0d times, %0d mismatches",
                 n_full, fail_count);
        if (fail_count == 0 && pending_grants.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rrrs_pkg.sv
sv/rrrs_cell.sv
sv/round_robin_rotation_scheduler.sv
test/tb_top.sv
